@@ hw/rtl/assert_macros.svh @@
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, muted while reset is asserted
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also runs during reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/hcbd_pkg.sv @@
// ----------------------------------------------------------------------------
// hcbd_pkg
// shared types and constants of the chunked body decoder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hcbd_pkg;

    localparam int COUNT_WIDTH_DEF = 32;

    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_SEMI = 8'h3B;

    // parser phases
    typedef enum logic [2:0] {
        PH_SIZE = 3'd0,
        PH_EXT  = 3'd1,
        PH_PRE  = 3'd2,
        PH_DATA = 3'd3,
        PH_POST = 3'd4,
        PH_DONE = 3'd5
    } phase_t;

    // one byte presented to the parser
    typedef struct packed {
        logic       step;
        logic [7:0] data;
        logic       last;
    } hcbd_step_t;

    // what the parser makes of that byte
    typedef struct packed {
        logic       emit;
        logic       end_seen;
        logic [7:0] data;
    } hcbd_result_t;

endpackage

@@ hw/rtl/http_chunked_body_decoder.sv @@
// ----------------------------------------------------------------------------
// http_chunked_body_decoder
// strips chunked transfer coding from an http body, one byte per item
// ----------------------------------------------------------------------------
// Feed the raw chunked body one byte per item on the s_axis side; only payload
// bytes come out on m_axis, plus one end marker (tuser high, tdata zero) when
// the zero-size chunk line is closed by its carriage return. Size lines take
// hex digits of either case into a COUNT_WIDTH-bit count that wraps; other
// characters are ignored, and a semicolon skips an extension up to the cr.
// CR and LF bytes before and after a chunk's data are skipped, so a payload
// that starts with cr or lf loses that byte. Bytes after the end marker are
// dropped. Raising tlast on an input byte handles that byte normally and then
// returns the parser to its initial state, with no marker for a cut body.
// Throughput is one byte per clock cycle while the output is not stalled; an
// accepted byte passes through the input register and the result register
// around the combinational parser step.
`timescale 1ns / 1ps

module http_chunked_body_decoder
    import hcbd_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,

    // raw body in
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,    // [7:0] data_byte
    input  logic       s_axis_tlast,    // last_of_input

    // decoded payload out
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,    // [7:0] out_byte
    output logic       m_axis_tuser     // [0] end_seen
);

    // input register
    logic         in_valid_reg;
    logic [7:0]   in_data_reg;
    logic         in_last_reg;

    // result register
    logic         out_valid_reg;
    logic [7:0]   out_data_reg;
    logic         out_end_reg;

    logic         in_accept;
    logic         advance;
    hcbd_step_t   step_in;
    hcbd_result_t result;

    // the held item moves through the parser whenever the result slot is
    // free or being emptied this cycle, so both sides can move in the same cycle
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    assign step_in.step = advance;
    assign step_in.data = in_data_reg;
    assign step_in.last = in_last_reg;

    hcbd_parser #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_in (step_in),
        .result  (result)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= result.emit;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_data_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
        if (advance && result.emit)
        begin
            out_data_reg <= result.data;
            out_end_reg  <= result.end_seen;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_end_reg;

endmodule

@@ hw/rtl/hcbd_parser.sv @@
// ----------------------------------------------------------------------------
// hcbd_parser
// phase machine and chunk counter, one byte per step
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hcbd_parser
    import hcbd_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  hcbd_step_t   step_in,
    output hcbd_result_t result
);

    phase_t                   phase_reg;
    phase_t                   phase_next;
    logic [COUNT_WIDTH-1:0]   count_reg;
    logic [COUNT_WIDTH-1:0]   count_next;

    logic                     is_cr;
    logic                     is_crlf;
    logic                     is_semi;
    logic                     is_hex;
    logic [3:0]               hex_val;
    logic                     count_zero;
    logic                     count_one;
    logic [COUNT_WIDTH-1:0]   count_dec;
    logic [COUNT_WIDTH-1:0]   count_acc;

    assign is_cr      = (step_in.data == CH_CR);
    assign is_crlf    = is_cr || (step_in.data == CH_LF);
    assign is_semi    = (step_in.data == CH_SEMI);
    assign count_zero = (count_reg == '0);
    assign count_one  = (count_reg == COUNT_WIDTH'(1));
    assign count_dec  = count_reg - COUNT_WIDTH'(1);
    assign count_acc  = {count_reg[COUNT_WIDTH-5:0], hex_val};

    // hex digit decode, either case
    always_comb
    begin
        is_hex  = 1'b1;
        hex_val = 4'd0;
        if (step_in.data >= 8'h30 && step_in.data <= 8'h39)
        begin
            hex_val = step_in.data[3:0];
        end
        else if ((step_in.data >= 8'h61 && step_in.data <= 8'h66) ||
                 (step_in.data >= 8'h41 && step_in.data <= 8'h46))
        begin
            hex_val = step_in.data[3:0] + 4'd9;
        end
        else
        begin
            is_hex = 1'b0;
        end
    end

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        unique case (phase_reg)
            PH_EXT:
            begin
                if (is_cr)
                begin
                    phase_next = count_zero ? PH_DONE : PH_PRE;
                end
            end
            PH_PRE, PH_DATA:
            begin
                if (phase_reg == PH_DATA || !is_crlf)
                begin
                    count_next = count_dec;
                    phase_next = count_one ? PH_POST : PH_DATA;
                end
            end
            PH_POST:
            begin
                // first byte of a new size line starts from a zero count
                if (!is_crlf)
                begin
                    count_next = '0;
                    phase_next = PH_SIZE;
                    if (is_semi)
                    begin
                        phase_next = PH_EXT;
                    end
                    else if (is_hex)
                    begin
                        count_next = COUNT_WIDTH'(hex_val);
                    end
                end
            end
            PH_DONE:
            begin
                phase_next = PH_DONE;
            end
            default:
            begin
                // size line, also taken by the unused codes
                phase_next = PH_SIZE;
                if (is_cr)
                begin
                    phase_next = count_zero ? PH_DONE : PH_PRE;
                end
                else if (is_semi)
                begin
                    phase_next = PH_EXT;
                end
                else if (is_hex)
                begin
                    count_next = count_acc;
                end
            end
        endcase
        if (step_in.last)
        begin
            phase_next = PH_SIZE;
            count_next = '0;
        end
    end

    // outputs
    always_comb
    begin
        result.emit     = 1'b0;
        result.end_seen = 1'b0;
        result.data     = step_in.data;
        unique case (phase_reg)
            PH_PRE:
            begin
                result.emit = !is_crlf;
            end
            PH_DATA:
            begin
                result.emit = 1'b1;
            end
            PH_POST, PH_DONE:
            begin
                result.emit = 1'b0;
            end
            default:
            begin
                // size line or extension: end marker on cr with zero count
                if (is_cr && count_zero)
                begin
                    result.emit     = 1'b1;
                    result.end_seen = 1'b1;
                    result.data     = 8'd0;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SIZE;
            count_reg <= '0;
        end
        else if (step_in.step)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
        end
    end

endmodule

@@ hw/rtl/hcbd_checker.sv @@
// ----------------------------------------------------------------------------
// hcbd_checker
// port-level checks of the chunked body decoder, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hcbd_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tuser
);

    // an end marker carries a zero byte
    `ASSERT_CLK(a_end_zero, clk, rst_n,
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 8'd0,
        "end marker with nonzero data")

    // an empty result slot never holds off the input
    `ASSERT_CLK(a_ready_when_empty, clk, rst_n,
        !m_axis_tvalid |-> s_axis_tready,
        "input stalled with no pending item")

    // a stalled item stays offered
    `ASSERT_CLK(a_out_hold, clk, rst_n,
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid,
        "item dropped while stalled")

    // a stalled item keeps its payload
    `ASSERT_CLK(a_out_stable, clk, rst_n,
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser),
        "item changed while stalled")

endmodule

bind http_chunked_body_decoder hcbd_checker u_hcbd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

@@ tb/sv/hcbd_payload_checker.sv @@
// ----------------------------------------------------------------------------
// hcbd_payload_checker
// predicts the decoded payload of the chunked body decoder and checks it
// ----------------------------------------------------------------------------
// Watches both stream channels. Every body byte accepted on the input runs
// through a private copy of the chunk parser; the payload bytes and end
// markers it yields are queued and compared in order with the items that
// leave the block.
`timescale 1ns / 1ps

module hcbd_payload_checker
    import hcbd_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,

    input  logic       s_axis_tvalid,
    input  logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,    // [7:0] data_byte
    input  logic       s_axis_tlast,    // last_of_input

    input  logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    input  logic [7:0] m_axis_tdata,    // [7:0] out_byte
    input  logic       m_axis_tuser,    // [0] end_seen

    output int         fail_count,
    output int         pending,
    output int         payload_count,
    output int         marker_count
);

    localparam int MAX_PRINTED = 40;

    phase_t                 phase;
    logic [COUNT_WIDTH-1:0] chunk_left;
    hcbd_result_t           payload_q[$];

    task automatic report_mismatch(input string what);
        if (fail_count < MAX_PRINTED)
            $display("mismatch at %0t ns: %s", $time, what);
        fail_count++;
    endtask

    // one character of a size line or of its extension
    task automatic size_line_char(input logic [7:0] c, output logic marker);
        logic [4:0] digit;
        marker = 1'b0;
        digit  = 5'h10;
        if (c == CH_CR) begin
            if (chunk_left == '0) begin
                phase  = PH_DONE;
                marker = 1'b1;
            end
            else
                phase = PH_PRE;
        end
        else if (phase != PH_EXT) begin
            if (c == CH_SEMI)
                phase = PH_EXT;
            else begin
                if (c >= "0" && c <= "9")
                    digit = {1'b0, c[3:0]};
                else if (c >= "a" && c <= "f")
                    digit = 5'(c - "a" + 8'd10);
                else if (c >= "A" && c <= "F")
                    digit = 5'(c - "A" + 8'd10);
                if (!digit[4])
                    chunk_left = {chunk_left[COUNT_WIDTH-5:0], digit[3:0]};
            end
        end
    endtask

    task automatic take_payload(input logic [7:0] c);
        hcbd_result_t r;
        r.emit     = 1'b1;
        r.end_seen = 1'b0;
        r.data     = c;
        payload_q.push_back(r);
        chunk_left = chunk_left - 1'b1;
        phase = (chunk_left == '0) ? PH_POST : PH_DATA;
    endtask

    task automatic predict_byte(input logic [7:0] c, input logic last_in);
        logic         crlf;
        logic         marker;
        hcbd_result_t r;
        crlf   = (c == CH_CR) || (c == CH_LF);
        marker = 1'b0;
        case (phase)
            PH_EXT:  size_line_char(c, marker);
            PH_PRE:  if (!crlf) take_payload(c);
            PH_DATA: take_payload(c);
            PH_POST:
            begin
                if (!crlf)
                begin
                    phase      = PH_SIZE;
                    chunk_left = '0;
                    size_line_char(c, marker);
                end
            end
            PH_DONE: ;
            default:
            begin
                phase = PH_SIZE;
                size_line_char(c, marker);
            end
        endcase
        if (marker)
        begin
            r.emit     = 1'b1;
            r.end_seen = 1'b1;
            r.data     = 8'h00;
            payload_q.push_back(r);
        end
        if (last_in)
        begin
            phase      = PH_SIZE;
            chunk_left = '0;
        end
    endtask

    task automatic check_result();
        hcbd_result_t want;
        if (payload_q.size() == 0)
            report_mismatch($sformatf("item out with nothing expected, data %h user %b",
                                      m_axis_tdata, m_axis_tuser));
        else
        begin
            want = payload_q.pop_front();
            if (m_axis_tdata !== want.data)
                report_mismatch($sformatf("out_byte %h, expected %h",
                                          m_axis_tdata, want.data));
            if (m_axis_tuser !== want.end_seen)
                report_mismatch($sformatf("end_seen %b, expected %b",
                                          m_axis_tuser, want.end_seen));
            if (want.end_seen)
                marker_count++;
            else
                payload_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase         = PH_SIZE;
            chunk_left    = '0;
            payload_q.delete();
            fail_count    = 0;
            payload_count = 0;
            marker_count  = 0;
            pending      <= 0;
        end
        else
        begin
            // predict first so that an item accepted now is already queued
            if (s_axis_tvalid && s_axis_tready)
                predict_byte(s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready)
                check_result();
            pending <= payload_q.size();
        end
    end

endmodule

@@ tb/sv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// stimulus and verdict for the chunked body decoder
// ----------------------------------------------------------------------------
// Builds a byte stream of directed cases and random chunked bodies (most of
// them well formed, some cut short, some plain noise), sends it in bursts,
// and takes the payload with a stalling receiver that once holds off long
// enough to back up the input. The checker beside the block does the rest.
`timescale 1ns / 1ps

module tb_top;
    import hcbd_pkg::*;

    localparam int BODY_TARGET  = 2000;
    localparam int HOLD_CYCLES  = 400;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 10;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } body_item_t;

    logic       clk           = 1'b0;
    logic       rst_n         = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'h00;
    logic       s_axis_tlast  = 1'b0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;
    logic       m_axis_tuser;

    int fail_count;
    int pending;
    int payload_count;
    int marker_count;

    body_item_t body_q[$];
    int         send_idx;
    int         burst_left;
    int         gap_left;
    int         hold_at;
    int         hold_left;
    logic       hold_done;
    logic [7:0] ready_pat;
    int         pat_age;
    int         n_messages;
    int         idle_cycles;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    http_chunked_body_decoder i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    hcbd_payload_checker i_payload_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .fail_count    (fail_count),
        .pending       (pending),
        .payload_count (payload_count),
        .marker_count  (marker_count)
    );

    task automatic add_byte(input logic [7:0] b, input logic last_in);
        body_item_t item;
        item.data = b;
        item.last = last_in;
        body_q.push_back(item);
    endtask

    task automatic add_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            add_byte(s[i], 1'b0);
    endtask

    task automatic mark_last();
        body_item_t item;
        item = body_q.pop_back();
        item.last = 1'b1;
        body_q.push_back(item);
    endtask

    // hex digit in random case
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10)
            return "0" + nib;
        else if ($urandom_range(0, 1) == 0)
            return "a" + (nib - 4'd10);
        else
            return "A" + (nib - 4'd10);
    endfunction

    // size line: optional zeros, an optional digit that wraps out of the
    // count, stray characters, an optional extension, then cr and usually lf
    task automatic add_size_line(input logic [31:0] value);
        int         nibbles;
        int         k;
        int         n_ext;
        logic [7:0] b;
        nibbles = 1;
        while (nibbles < 8 && (value >> (4 * nibbles)) != 0)
            nibbles++;
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 2)) add_byte("0", 1'b0);
        if ($urandom_range(0, 24) == 0)
        begin
            add_byte(hex_char(4'($urandom_range(1, 15))), 1'b0);
            nibbles = 8;
        end
        for (k = nibbles - 1; k >= 0; k--)
        begin
            add_byte(hex_char(value[4 * k +: 4]), 1'b0);
            if ($urandom_range(0, 19) == 0)
                add_byte(($urandom_range(0, 1) == 0) ? " " : "x", 1'b0);
        end
        if ($urandom_range(0, 4) == 0)
        begin
            add_byte(CH_SEMI, 1'b0);
            n_ext = $urandom_range(0, 6);
            repeat (n_ext)
            begin
                b = 8'($urandom_range(0, 255));
                add_byte((b == CH_CR) ? "=" : b, 1'b0);
            end
        end
        add_byte(CH_CR, 1'b0);
        if ($urandom_range(0, 9) != 0)
            add_byte(CH_LF, 1'b0);
    endtask

    // one chunked body with random content; sometimes cut, rarely unterminated
    task automatic add_message();
        int n_chunks;
        int k;
        int j;
        int size;
        int roll;
        int start;
        int cut_at;
        start    = body_q.size();
        n_chunks = $urandom_range(0, 4);
        for (k = 0; k < n_chunks; k++)
        begin
            roll = $urandom_range(0, 19);
            if (roll == 0)
                size = $urandom_range(41, 200);
            else if (roll < 5)
                size = $urandom_range(9, 40);
            else
                size = $urandom_range(1, 8);
            add_size_line(size);
            for (j = 0; j < size; j++)
            begin
                // a leading cr or lf gets swallowed by the parser
                if (j == 0 && $urandom_range(0, 6) == 0)
                    add_byte(($urandom_range(0, 1) == 0) ? CH_CR : CH_LF, 1'b0);
                else
                    add_byte(8'($urandom_range(0, 255)), 1'b0);
            end
            roll = $urandom_range(0, 9);
            if (roll == 1)
                add_byte(CH_LF, 1'b0);
            else if (roll == 2)
            begin
                add_byte(CH_CR, 1'b0);
                add_byte(CH_CR, 1'b0);
                add_byte(CH_LF, 1'b0);
                add_byte(CH_LF, 1'b0);
            end
            else if (roll != 0)
            begin
                add_byte(CH_CR, 1'b0);
                add_byte(CH_LF, 1'b0);
            end
        end
        add_size_line(32'd0);
        // trailer bytes after the end marker are dropped
        repeat ($urandom_range(0, 3)) add_byte(8'($urandom_range(0, 255)), 1'b0);
        if ($urandom_range(0, 9) == 0)
        begin
            cut_at = $urandom_range(start, body_q.size() - 1);
            while (body_q.size() > cut_at + 1)
                void'(body_q.pop_back());
        end
        if ($urandom_range(0, 19) != 0)
            mark_last();
    endtask

    // sender: bursts of random length with random gaps between them
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'h00;
            s_axis_tlast  <= 1'b0;
            send_idx      <= 0;
            burst_left    <= 1;
            gap_left      <= 0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (gap_left != 0 || send_idx >= body_q.size())
            begin
                s_axis_tvalid <= 1'b0;
                if (gap_left != 0)
                    gap_left <= gap_left - 1;
            end
            else
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= body_q[send_idx].data;
                s_axis_tlast  <= body_q[send_idx].last;
                send_idx      <= send_idx + 1;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 48);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                end
                else
                    burst_left <= burst_left - 1;
            end
        end
    end

    // receiver: rotating ready pattern, reloaded now and then, plus one
    // long hold-off while the sender keeps offering
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            ready_pat     <= 8'hFF;
            pat_age       <= 0;
            hold_left     <= 0;
            hold_done     <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end
        else if (!hold_done && send_idx >= hold_at)
        begin
            m_axis_tready <= 1'b0;
            hold_left     <= HOLD_CYCLES;
            hold_done     <= 1'b1;
        end
        else
        begin
            m_axis_tready <= ready_pat[0];
            if (pat_age == 99)
            begin
                pat_age   <= 0;
                ready_pat <= ($urandom_range(0, 3) == 0) ? 8'hFF
                                                         : (8'($urandom) | 8'h01);
            end
            else
            begin
                pat_age   <= pat_age + 1;
                ready_pat <= {ready_pat[0], ready_pat[7:1]};
            end
        end
    end

    // watchdog on cycles with no item moving on either side
    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("watchdog: no item moved for %0d cycles", IDLE_LIMIT);
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial
    begin
        // directed: extension, leading lf in data, extreme bytes, end marker,
        // byte after the end with tlast, wrapping count cut short by tlast
        add_text("2;E");
        add_byte(CH_CR, 1'b0);
        add_byte(CH_LF, 1'b0);
        add_byte(CH_LF, 1'b0);
        add_byte(8'h00, 1'b0);
        add_byte(8'hFF, 1'b0);
        add_byte(CH_CR, 1'b0);
        add_byte(CH_LF, 1'b0);
        add_text("0");
        add_byte(CH_CR, 1'b0);
        add_byte(CH_LF, 1'b0);
        add_byte("q", 1'b1);
        add_text("100000002");
        add_byte(CH_CR, 1'b0);
        add_byte(CH_LF, 1'b0);
        add_byte("Z", 1'b1);
        n_messages = 2;

        while (body_q.size() < BODY_TARGET)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                // noise with scattered tlast
                repeat ($urandom_range(1, 16))
                    add_byte(8'($urandom_range(0, 255)), ($urandom_range(0, 7) == 0));
                if ($urandom_range(0, 9) < 7)
                    mark_last();
            end
            else
                add_message();
            n_messages++;
        end
        hold_at = body_q.size() / 3;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(posedge clk);
        while (send_idx < body_q.size() || s_axis_tvalid || pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d body bytes in %0d bodies and noise runs",
                 body_q.size(), n_messages);
        $display("checked %0d payload bytes and %0d end markers, %0d mismatches",
                 payload_count, marker_count, fail_count);
        if (fail_count == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
